FILE: sv/dgcd_pkg.sv
package dgcd_pkg;

    // Operation select codes on the func field.
    localparam logic FUNC_DIV = 1'b0;
    localparam logic FUNC_GCD = 1'b1;

    // Handshake between the controller and the serial divider.
    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage

FILE: sv/dgcd_ifs.sv
interface dgcd_req_if #(
    parameter int WIDTH = 32
) ();
    logic             valid;
    logic             ready;
    logic             func;
    logic [WIDTH-1:0] operand_a;
    logic [WIDTH-1:0] operand_b;

    modport source (output valid, func, operand_a, operand_b, input ready);
    modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface dgcd_rsp_if #(
    parameter int WIDTH = 32
) ();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] value;
    logic             div_zero;

    modport source (output valid, quotient, value, div_zero, input ready);
    modport sink   (input valid, quotient, value, div_zero, output ready);
endinterface

FILE: sv/dgcd_div.sv
module dgcd_div
    import dgcd_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output div_ctl_t         ctl,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_W  = $clog2(WIDTH + 1);
    localparam int ITER_W = $clog2(WIDTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_SUB   = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              borrow_reg, borrow_next;
    logic              done_reg, done_next;
    logic [WIDTH-1:0]  aq_reg, aq_next;
    logic [WIDTH:0]    rem_reg, rem_next;
    logic [WIDTH:0]    dsr_reg, dsr_next;
    logic [WIDTH:0]    diff_reg, diff_next;

    logic              diff_bit;
    logic              borrow_out;
    logic [WIDTH:0]    rem_rot;

    // One-bit subtractor working on the low bits of the rotating registers.
    assign diff_bit   = rem_reg[0] ^ dsr_reg[0] ^ borrow_reg;
    assign borrow_out = (~rem_reg[0] & dsr_reg[0])
                      | (~(rem_reg[0] ^ dsr_reg[0]) & borrow_reg);
    assign rem_rot    = {rem_reg[0], rem_reg[WIDTH:1]};

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        iter_next   = iter_reg;
        borrow_next = borrow_reg;
        done_next   = 1'b0;
        aq_next     = aq_reg;
        rem_next    = rem_reg;
        dsr_next    = dsr_reg;
        diff_next   = diff_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    aq_next    = dividend;
                    dsr_next   = {1'b0, divisor};
                    rem_next   = '0;
                    iter_next  = '0;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                rem_next    = {rem_reg[WIDTH-1:0], aq_reg[WIDTH-1]};
                aq_next     = {aq_reg[WIDTH-2:0], 1'b0};
                cnt_next    = '0;
                borrow_next = 1'b0;
                state_next  = S_SUB;
            end
            S_SUB:
            begin
                rem_next    = rem_rot;
                dsr_next    = {dsr_reg[0], dsr_reg[WIDTH:1]};
                diff_next   = {diff_bit, diff_reg[WIDTH:1]};
                borrow_next = borrow_out;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WIDTH))
                begin
                    // The full word has passed: keep the difference if no borrow came out.
                    if (!borrow_out)
                    begin
                        rem_next = {diff_bit, diff_reg[WIDTH:1]};
                    end
                    aq_next[0] = ~borrow_out;
                    if (iter_reg == ITER_W'(WIDTH - 1))
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        iter_next  = iter_reg + ITER_W'(1);
                        state_next = S_SHIFT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        iter_reg   <= iter_next;
        borrow_reg <= borrow_next;
        aq_reg     <= aq_next;
        rem_reg    <= rem_next;
        dsr_reg    <= dsr_next;
        diff_reg   <= diff_next;
    end

    assign ctl.start = start;
    assign ctl.done  = done_reg;
    assign quotient  = aq_reg;
    assign remainder = rem_reg[WIDTH-1:0];

endmodule

FILE: sv/doubling_divider_gcd_unit_top.sv
// Channel   Modport  Transfer when        Payload
// req       sink     valid && ready       func, operand_a, operand_b
// rsp       source   valid && ready       quotient, value, div_zero
//
// One division takes WIDTH iterations of the bit-serial subtractor, each a shift
// state followed by a serial subtract pass over the word.
// A gcd runs one such division per Euclid step; a zero divisor skips the divider.
// The divider is the serial subtract loop in dgcd_div. One item is in work at a time.
// Reset clears the control state only. A finished result waits in the output
// register while the next item is accepted and worked on.
module doubling_divider_gcd_unit_top
    import dgcd_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input logic       clk,
    input logic       rst_n,
    dgcd_req_if.sink  req,
    dgcd_rsp_if.source rsp
);

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_CHECK = 2'd1;
    localparam logic [1:0] T_RUN   = 2'd2;
    localparam logic [1:0] T_OUT   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             func_reg, func_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] q_reg, q_next;
    logic             dz_reg, dz_next;
    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] out_q_reg, out_q_next;
    logic [WIDTH-1:0] out_v_reg, out_v_next;
    logic             out_dz_reg, out_dz_next;

    logic             div_start;
    div_ctl_t         div_ctl;
    logic [WIDTH-1:0] div_q;
    logic [WIDTH-1:0] div_r;
    logic             slot_free;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign div_start = (state_reg == T_CHECK) && (b_reg != '0);

    dgcd_div #(
        .WIDTH (WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .ctl       (div_ctl),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        q_next         = q_reg;
        dz_next        = dz_reg;
        out_valid_next = out_valid_reg;
        out_q_next     = out_q_reg;
        out_v_next     = out_v_reg;
        out_dz_next    = out_dz_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            T_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = req.func;
                    a_next     = req.operand_a;
                    b_next     = req.operand_b;
                    state_next = T_CHECK;
                end
            end
            T_CHECK:
            begin
                // A zero second operand ends a gcd, and is an error for a division.
                if (b_reg == '0)
                begin
                    q_next     = '0;
                    dz_next    = (func_reg == FUNC_DIV);
                    state_next = T_OUT;
                end
                else
                begin
                    state_next = T_RUN;
                end
            end
            T_RUN:
            begin
                if (div_ctl.done)
                begin
                    if (func_reg == FUNC_GCD)
                    begin
                        a_next     = b_reg;
                        b_next     = div_r;
                        state_next = T_CHECK;
                    end
                    else
                    begin
                        a_next     = div_r;
                        q_next     = div_q;
                        dz_next    = 1'b0;
                        state_next = T_OUT;
                    end
                end
            end
            T_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_q_next     = q_reg;
                    out_v_next     = a_reg;
                    out_dz_next    = dz_reg;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        q_reg      <= q_next;
        dz_reg     <= dz_next;
        out_q_reg  <= out_q_next;
        out_v_reg  <= out_v_next;
        out_dz_reg <= out_dz_next;
    end

    assign req.ready    = (state_reg == T_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.quotient = out_q_reg;
    assign rsp.value    = out_v_reg;
    assign rsp.div_zero = out_dz_reg;

endmodule

FILE: test/tb.sv
module tb;
    import dgcd_pkg::*;

    localparam int WIDTH = 32;
    localparam logic [63:0] WMASK = (64'd1 << WIDTH) - 64'd1;
    localparam int NUM_VECTORS = 21;
    localparam int NUM_RANDOM = 730;
    localparam int QUIET_FIRST = 200;
    localparam int QUIET_LAST = 349;
    localparam int DRAIN_AT = 400;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int TAIL_CYCLES = 100;
    localparam int IDLE_PERCENT = 27;

    localparam logic BY_HAND = 1'b1;
    localparam logic BY_MODEL = 1'b0;

    localparam logic [WIDTH-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic             func;
        logic [WIDTH-1:0] operand_a;
        logic [WIDTH-1:0] operand_b;
    } request_t;

    typedef struct packed {
        logic [WIDTH-1:0] quotient;
        logic [WIDTH-1:0] value;
        logic             div_zero;
    } result_t;

    typedef struct packed {
        logic             func;
        logic [WIDTH-1:0] operand_a;
        logic [WIDTH-1:0] operand_b;
        logic             source;
        logic [WIDTH-1:0] quotient;
        logic [WIDTH-1:0] value;
        logic             div_zero;
    } vector_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic quiet = 1'b0;
    int   fail_count = 0;
    int   stall_cycles = 0;

    result_t pending_results[$];
    result_t oldest;

    vector_row_t vectors [NUM_VECTORS] = '{
        '{FUNC_DIV, 32'h0000_0000, 32'h0000_0001, BY_HAND, 32'h0000_0000, 32'h0000_0000, 1'b0},
        '{FUNC_DIV, ALL_ONES, 32'h0000_0001, BY_HAND, ALL_ONES, 32'h0000_0000, 1'b0},
        '{FUNC_DIV, ALL_ONES, ALL_ONES, BY_HAND, 32'h0000_0001, 32'h0000_0000, 1'b0},
        '{FUNC_DIV, 32'h0000_0000, ALL_ONES, BY_HAND, 32'h0000_0000, 32'h0000_0000, 1'b0},
        '{FUNC_DIV, 32'h0000_0001, ALL_ONES, BY_HAND, 32'h0000_0000, 32'h0000_0001, 1'b0},
        '{FUNC_DIV, 32'h0000_0005, 32'h0000_0000, BY_HAND, 32'h0000_0000, 32'h0000_0005, 1'b1},
        '{FUNC_DIV, ALL_ONES, 32'h0000_0000, BY_HAND, 32'h0000_0000, ALL_ONES, 1'b1},
        '{FUNC_DIV, 32'h0000_0000, 32'h0000_0000, BY_HAND, 32'h0000_0000, 32'h0000_0000, 1'b1},
        '{FUNC_DIV, 32'h0000_0007, 32'h0000_0008, BY_HAND, 32'h0000_0000, 32'h0000_0007, 1'b0},
        '{FUNC_DIV, 32'h8000_0000, 32'h8000_0001, BY_HAND, 32'h0000_0000, 32'h8000_0000, 1'b0},
        '{FUNC_DIV, ALL_ONES, 32'h8000_0000, BY_HAND, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0},
        '{FUNC_DIV, 32'h0000_0064, 32'h0000_0007, BY_MODEL, '0, '0, 1'b0},
        '{FUNC_DIV, 32'hFFFF_FFFE, 32'h0000_0003, BY_MODEL, '0, '0, 1'b0},
        '{FUNC_GCD, 32'h0000_0000, 32'h0000_0000, BY_HAND, 32'h0000_0000, 32'h0000_0000, 1'b0},
        '{FUNC_GCD, 32'h0000_000C, 32'h0000_0000, BY_HAND, 32'h0000_0000, 32'h0000_000C, 1'b0},
        '{FUNC_GCD, 32'h0000_0000, 32'h0000_000C, BY_HAND, 32'h0000_0000, 32'h0000_000C, 1'b0},
        '{FUNC_GCD, ALL_ONES, ALL_ONES, BY_HAND, 32'h0000_0000, ALL_ONES, 1'b0},
        '{FUNC_GCD, ALL_ONES, 32'h0000_0001, BY_HAND, 32'h0000_0000, 32'h0000_0001, 1'b0},
        '{FUNC_GCD, 32'h0000_0030, 32'h0000_0012, BY_MODEL, '0, '0, 1'b0},
        '{FUNC_GCD, 32'h8000_0000, 32'h4000_0000, BY_MODEL, '0, '0, 1'b0},
        // Consecutive Fibonacci numbers take the longest chain of remainders.
        '{FUNC_GCD, 32'd2971215073, 32'd1836311903, BY_MODEL, '0, '0, 1'b0}
    };

    dgcd_req_if #(.WIDTH(WIDTH)) req_ch ();
    dgcd_rsp_if #(.WIDTH(WIDTH)) rsp_ch ();

    doubling_divider_gcd_unit_top #(.WIDTH(WIDTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Double the divisor up to the dividend, then halve back down,
    // subtracting wherever it fits. The divisor must be nonzero.
    function automatic void double_halve_div(input logic [63:0] dividend,
                                             input logic [63:0] divisor,
                                             output logic [63:0] quot,
                                             output logic [63:0] rem);
        logic [63:0] left;
        logic [63:0] step;
        logic [63:0] acc;
        left = dividend;
        step = divisor;
        if (left < divisor)
        begin
            quot = 64'd0;
            rem = left;
        end
        else
        begin
            while (left - step >= step)
                step = step + step;
            acc = 64'd1;
            left = left - step;
            while (step != divisor)
            begin
                step = step >> 1;
                acc = (acc + acc) & WMASK;
                if (step <= left)
                begin
                    left = left - step;
                    acc = (acc + 64'd1) & WMASK;
                end
            end
            quot = acc;
            rem = left;
        end
    endfunction

    function automatic logic [63:0] gcd_by_remainders(input logic [63:0] first,
                                                     input logic [63:0] second);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] q;
        logic [63:0] r;
        x = first;
        y = second;
        while (y != 64'd0)
        begin
            double_halve_div(x, y, q, r);
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic result_t predict_result(input request_t item);
        result_t     res;
        logic [63:0] q;
        logic [63:0] r;
        res = '0;
        if (item.func == FUNC_DIV)
        begin
            if (item.operand_b == '0)
            begin
                res.value = item.operand_a;
                res.div_zero = 1'b1;
            end
            else
            begin
                double_halve_div(64'(item.operand_a), 64'(item.operand_b), q, r);
                res.quotient = q[WIDTH-1:0];
                res.value = r[WIDTH-1:0];
            end
        end
        else
        begin
            r = gcd_by_remainders(64'(item.operand_a), 64'(item.operand_b));
            res.value = r[WIDTH-1:0];
        end
        return res;
    endfunction

    // Every gcd costs one full division per remainder, so most gcd items are
    // kept small and only a few use two full-width operands.
    function automatic request_t random_request();
        request_t item;
        int       pick;
        item.func = ($urandom_range(0, 99) < 20) ? FUNC_GCD : FUNC_DIV;
        pick = $urandom_range(0, 99);
        if (item.func == FUNC_DIV)
        begin
            item.operand_a = ($urandom_range(0, 99) < 85) ? $urandom() : $urandom_range(0, 255);
            if (pick < 8)
                item.operand_b = '0;
            else if (pick < 35)
                item.operand_b = $urandom_range(1, 255);
            else if (pick < 65)
                item.operand_b = item.operand_a >> $urandom_range(0, 31);
            else
                item.operand_b = $urandom();
        end
        else
        begin
            if (pick < 70)
            begin
                item.operand_a = $urandom_range(0, 63);
                item.operand_b = $urandom_range(0, 63);
            end
            else if (pick < 92)
            begin
                item.operand_a = $urandom();
                item.operand_b = $urandom_range(0, 255);
            end
            else
            begin
                item.operand_a = $urandom();
                item.operand_b = $urandom();
            end
        end
        return item;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input request_t item, input result_t expected);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= item.func;
        req_ch.operand_a <= item.operand_a;
        req_ch.operand_b <= item.operand_b;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(expected);
        @(negedge clk);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    always @(negedge clk)
        rsp_ch.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing pending");
                fail_count = fail_count + 1;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (rsp_ch.quotient !== oldest.quotient)
                begin
                    $error("quotient: expected %h, actual %h", oldest.quotient, rsp_ch.quotient);
                    fail_count = fail_count + 1;
                end
                if (rsp_ch.value !== oldest.value)
                begin
                    $error("value: expected %h, actual %h", oldest.value, rsp_ch.value);
                    fail_count = fail_count + 1;
                end
                if (rsp_ch.div_zero !== oldest.div_zero)
                begin
                    $error("div_zero: expected %b, actual %b", oldest.div_zero,
                           rsp_ch.div_zero);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    initial
    begin
        request_t item;
        result_t  expected;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_DIV;
        req_ch.operand_a = '0;
        req_ch.operand_b = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_VECTORS; i++)
        begin
            item.func = vectors[i].func;
            item.operand_a = vectors[i].operand_a;
            item.operand_b = vectors[i].operand_b;
            if (vectors[i].source == BY_HAND)
            begin
                expected.quotient = vectors[i].quotient;
                expected.value = vectors[i].value;
                expected.div_zero = vectors[i].div_zero;
            end
            else
                expected = predict_result(item);
            send_request(item, expected);
        end
        drain_results();

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            quiet <= (i >= QUIET_FIRST && i <= QUIET_LAST);
            if (i == DRAIN_AT)
                drain_results();
            item = random_request();
            send_request(item, predict_result(item));
        end
        req_ch.valid <= 1'b0;
        quiet <= 1'b0;

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: sim.f
sv/dgcd_pkg.sv
sv/dgcd_ifs.sv
sv/dgcd_div.sv
sv/doubling_divider_gcd_unit_top.sv
test/tb.sv
